/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the elevator car controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg
// Types, codes, reset values and search functions of the elevator car
// controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int NUM_FLOORS_DEF = 16;
  localparam int FLOOR_W        = 4;
  localparam int MAP_W          = 16;
  localparam int CNT_W          = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CNT_W-1:0] OPEN_TIME_RST  = 8'd2;
  localparam logic [CNT_W-1:0] DWELL_TIME_RST = 8'd3;
  localparam logic [CNT_W-1:0] CLOSE_TIME_RST = 8'd2;
  localparam logic [CNT_W-1:0] CAPACITY_RST   = 8'd12;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_HALL  = 3'd1,
    FN_CAR   = 3'd2,
    FN_BOARD = 3'd3,
    FN_DROP  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_MOVE  = 2'd0,
    PH_OPEN  = 2'd1,
    PH_DWELL = 2'd2,
    PH_CLOSE = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_TIME  = 2'd0,
    CFG_DWELL_TIME = 2'd1,
    CFG_CLOSE_TIME = 2'd2,
    CFG_CAPACITY   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] open_time;
    logic [CNT_W-1:0] dwell_time;
    logic [CNT_W-1:0] close_time;
    logic [CNT_W-1:0] car_capacity;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [FLOOR_W-1:0] call_floor;
    logic               call_dir;
    logic [FLOOR_W-1:0] dest_floor;
    logic [CNT_W-1:0]   board_count;
  } item_t;

  typedef struct packed {
    logic [MAP_W-1:0]   down_pending;
    logic [MAP_W-1:0]   up_pending;
    logic [FLOOR_W-1:0] current_target;
    logic [CNT_W-1:0]   dropped;
    logic [CNT_W-1:0]   car_load;
    logic [1:0]         door_phase;
    logic               door_is_open;
    logic [1:0]         car_dir;
    logic [FLOOR_W-1:0] car_floor;
  } status_t;

  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] target;
    dir_t               dir;
  } sched_t;

  typedef struct packed {
    logic               hit;
    logic [FLOOR_W-1:0] idx;
  } hit_t;

  // Lowest set bit at or above floor f.
  function automatic hit_t first_at_or_above(logic [MAP_W-1:0] v, logic [FLOOR_W-1:0] f);
    hit_t r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i] && (FLOOR_W'(i) >= f)) begin
        r.hit = 1'b1;
        r.idx = FLOOR_W'(i);
      end
    end
    return r;
  endfunction

  // Highest set bit at or below floor f.
  function automatic hit_t last_at_or_below(logic [MAP_W-1:0] v, logic [FLOOR_W-1:0] f);
    hit_t r;
    r = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (v[i] && (FLOOR_W'(i) <= f)) begin
        r.hit = 1'b1;
        r.idx = FLOOR_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/ecc_sched.sv */
// ----------------------------------------------------------------------------
// ecc_sched
// LOOK stop selection: the nearest stop ahead, one reversal, then the nearest
// pending stop of either bitmap.
// ----------------------------------------------------------------------------
module ecc_sched (
  input  logic [ecc_pkg::FLOOR_W-1:0] floor_i,
  input  ecc_pkg::dir_t               dir_i,
  input  logic [ecc_pkg::MAP_W-1:0]   up_i,
  input  logic [ecc_pkg::MAP_W-1:0]   down_i,
  output ecc_pkg::sched_t             sched_o
);
  import ecc_pkg::*;

  logic [MAP_W-1:0]   all_stops;
  dir_t               dir_start;
  dir_t               dir_flip;
  hit_t               up_ahead;
  hit_t               down_ahead;
  hit_t               near_above;
  hit_t               near_below;
  logic [FLOOR_W-1:0] dist_above;
  logic [FLOOR_W-1:0] dist_below;

  assign all_stops  = up_i | down_i;
  assign up_ahead   = first_at_or_above(up_i, floor_i);
  assign down_ahead = last_at_or_below(down_i, floor_i);
  assign near_above = first_at_or_above(all_stops, floor_i);
  assign near_below = last_at_or_below(all_stops, floor_i);
  assign dist_above = near_above.idx - floor_i;
  assign dist_below = floor_i - near_below.idx;

  always_comb begin
    if (dir_i == DIR_UP || dir_i == DIR_DOWN) begin
      dir_start = dir_i;
    end else if (up_i != '0) begin
      dir_start = DIR_UP;
    end else begin
      dir_start = DIR_DOWN;
    end
    dir_flip = (dir_start == DIR_UP) ? DIR_DOWN : DIR_UP;
  end

  always_comb begin
    sched_o       = '0;
    sched_o.dir   = dir_start;
    sched_o.found = (all_stops != '0);
    if (dir_start == DIR_UP && up_ahead.hit) begin
      sched_o.target = up_ahead.idx;
    end else if (dir_start == DIR_DOWN && down_ahead.hit) begin
      sched_o.target = down_ahead.idx;
    end else begin
      if ((dir_start == DIR_UP) ? (down_i != '0) : (up_i != '0)) begin
        sched_o.dir = dir_flip;
      end
      if (dir_flip == DIR_UP && up_i != '0 && up_ahead.hit) begin
        sched_o.target = up_ahead.idx;
      end else if (dir_flip == DIR_DOWN && down_i != '0 && down_ahead.hit) begin
        sched_o.target = down_ahead.idx;
      end else if (near_below.hit && (!near_above.hit || dist_below <= dist_above)) begin
        sched_o.target = near_below.idx;
      end else begin
        sched_o.target = near_above.idx;
      end
    end
  end

endmodule

/* rtl/ecc_core.sv */
// ----------------------------------------------------------------------------
// ecc_core
// Car state registers, drop-off count store and the event update that runs
// once for each item taken from the input register.
// ----------------------------------------------------------------------------
module ecc_core #(
  parameter int NUM_FLOORS = ecc_pkg::NUM_FLOORS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  ecc_pkg::item_t   item_i,
  input  ecc_pkg::cfg_t    cfg_i,
  output ecc_pkg::status_t status_o
);
  import ecc_pkg::*;

  localparam int          FLOOR_LIMIT = (NUM_FLOORS < MAP_W) ? NUM_FLOORS : MAP_W;
  localparam logic [FLOOR_W:0] FLOOR_LIM = (FLOOR_W + 1)'(FLOOR_LIMIT);

  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  dir_t               dir_r, dir_nxt;
  logic [FLOOR_W-1:0] target_r, target_nxt;
  logic [MAP_W-1:0]   up_r, up_nxt;
  logic [MAP_W-1:0]   down_r, down_nxt;
  logic               door_open_r, door_open_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   timer_r, timer_nxt;
  logic [CNT_W-1:0]   load_r, load_nxt;
  logic [CNT_W-1:0]   drop_cnt_r [MAP_W];

  logic [FLOOR_W-1:0] drop_addr;
  logic [CNT_W-1:0]   drop_rd;
  logic               drop_we;
  logic [CNT_W-1:0]   drop_wd;
  logic [CNT_W-1:0]   dropped;
  logic [CNT_W:0]     drop_sum;
  logic [CNT_W:0]     load_sum;
  sched_t             sched;

  function automatic logic floor_ok(logic [FLOOR_W-1:0] f);
    return {1'b0, f} < FLOOR_LIM;
  endfunction

  function automatic logic [MAP_W-1:0] floor_bit(logic [FLOOR_W-1:0] f);
    return MAP_W'(1) << f;
  endfunction

  ecc_sched u_sched (
    .floor_i (floor_r),
    .dir_i   (dir_r),
    .up_i    (up_r),
    .down_i  (down_r),
    .sched_o (sched)
  );

  assign drop_addr = (item_i.func == FN_DROP) ? floor_r : item_i.dest_floor;
  assign drop_rd   = drop_cnt_r[drop_addr];
  assign drop_sum  = {1'b0, drop_rd} + {1'b0, item_i.board_count};
  assign load_sum  = {1'b0, load_r} + {1'b0, item_i.board_count};

  always_comb begin
    floor_nxt     = floor_r;
    dir_nxt       = dir_r;
    target_nxt    = target_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    door_open_nxt = door_open_r;
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    load_nxt      = load_r;
    drop_we       = 1'b0;
    drop_wd       = '0;
    dropped       = '0;
    case (item_i.func)
      FN_TICK: begin
        if (phase_r != PH_MOVE) begin
          if (timer_r > 8'd1) begin
            timer_nxt = timer_r - 8'd1;
          end else begin
            timer_nxt = '0;
            case (phase_r)
              PH_OPEN: begin
                phase_nxt = PH_DWELL;
                timer_nxt = cfg_i.dwell_time;
              end
              PH_DWELL: begin
                phase_nxt     = PH_CLOSE;
                timer_nxt     = cfg_i.close_time;
                door_open_nxt = 1'b0;
              end
              PH_CLOSE: phase_nxt = PH_MOVE;
              default: ;
            endcase
          end
        end else if (!sched.found) begin
          dir_nxt = DIR_IDLE;
        end else begin
          target_nxt = sched.target;
          dir_nxt    = sched.dir;
          if (floor_r < sched.target) begin
            floor_nxt = floor_r + 4'd1;
            dir_nxt   = DIR_UP;
          end else if (floor_r > sched.target) begin
            floor_nxt = floor_r - 4'd1;
            dir_nxt   = DIR_DOWN;
          end else begin
            up_nxt        = up_r & ~floor_bit(floor_r);
            down_nxt      = down_r & ~floor_bit(floor_r);
            door_open_nxt = 1'b1;
            phase_nxt     = PH_OPEN;
            timer_nxt     = cfg_i.open_time;
          end
        end
      end
      FN_HALL: begin
        if (floor_ok(item_i.call_floor)) begin
          if (!item_i.call_dir) begin
            up_nxt = up_nxt | floor_bit(item_i.call_floor);
          end else begin
            down_nxt = down_nxt | floor_bit(item_i.call_floor);
          end
          if (item_i.dest_floor != '0 && floor_ok(item_i.dest_floor)) begin
            if (item_i.dest_floor > item_i.call_floor) begin
              up_nxt = up_nxt | floor_bit(item_i.dest_floor);
            end else begin
              down_nxt = down_nxt | floor_bit(item_i.dest_floor);
            end
          end
          if (dir_r == DIR_IDLE) begin
            dir_nxt    = (item_i.call_floor > floor_r) ? DIR_UP : DIR_DOWN;
            target_nxt = item_i.call_floor;
          end
        end
      end
      FN_CAR: begin
        if (floor_ok(item_i.call_floor) && item_i.call_floor != floor_r) begin
          if (item_i.call_floor > floor_r) begin
            up_nxt = up_r | floor_bit(item_i.call_floor);
          end else begin
            down_nxt = down_r | floor_bit(item_i.call_floor);
          end
        end
      end
      FN_BOARD: begin
        if (item_i.board_count != '0 && item_i.dest_floor != floor_r &&
            floor_ok(item_i.dest_floor)) begin
          if (item_i.dest_floor > floor_r) begin
            up_nxt = up_r | floor_bit(item_i.dest_floor);
          end else begin
            down_nxt = down_r | floor_bit(item_i.dest_floor);
          end
          drop_we  = 1'b1;
          drop_wd  = drop_sum[CNT_W] ? '1 : drop_sum[CNT_W-1:0];
          load_nxt = (load_sum < {1'b0, cfg_i.car_capacity}) ? load_sum[CNT_W-1:0]
                                                             : cfg_i.car_capacity;
        end
      end
      FN_DROP: begin
        drop_we  = 1'b1;
        drop_wd  = '0;
        dropped  = drop_rd;
        load_nxt = (load_r > drop_rd) ? load_r - drop_rd : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r     <= '0;
      dir_r       <= DIR_IDLE;
      target_r    <= '0;
      up_r        <= '0;
      down_r      <= '0;
      door_open_r <= 1'b0;
      phase_r     <= PH_MOVE;
      timer_r     <= '0;
      load_r      <= '0;
    end else if (step_i) begin
      floor_r     <= floor_nxt;
      dir_r       <= dir_nxt;
      target_r    <= target_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      door_open_r <= door_open_nxt;
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      load_r      <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_W; i++) begin
        drop_cnt_r[i] <= '0;
      end
    end else if (step_i && drop_we) begin
      drop_cnt_r[drop_addr] <= drop_wd;
    end
  end

  always_comb begin
    status_o.car_floor      = floor_nxt;
    status_o.car_dir        = dir_nxt;
    status_o.door_is_open   = door_open_nxt;
    status_o.door_phase     = phase_nxt;
    status_o.car_load       = load_nxt;
    status_o.dropped        = dropped;
    status_o.current_target = target_nxt;
    status_o.up_pending     = up_nxt;
    status_o.down_pending   = down_nxt;
  end

endmodule

/* rtl/elevator_car_controller.sv */
// ----------------------------------------------------------------------------
// elevator_car_controller
// One elevator car scheduled by the LOOK rule, driven by a stream of events
// and answering each event with one status item.
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle while the output is taken,
// and returns one status item for each event. The status is registered: the
// event is held in an input register, then the car state is updated and the
// status lands in the output register; a stalled output keeps the event in
// the input register. The one state update per cycle sets that rate, since
// each event sees the state the previous event left. While a finished status
// waits to be taken, the input register takes one more event and the input
// side then stalls until the status is taken. Timer and capacity registers
// are to be written by the user through the cfg_ port while no event is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_car_controller #(
  parameter int NUM_FLOORS = ecc_pkg::NUM_FLOORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // call_floor[3:0], call_dir[4], dest_floor[8:5], board_count[16:9], zero fill
  input  logic [23:0]                   in_tdata,
  // func[2:0]
  input  logic [2:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // car_floor[3:0], car_dir[5:4], door_is_open[6], door_phase[8:7],
  // car_load[16:9], dropped[24:17], current_target[28:25],
  // up_pending[44:29], down_pending[60:45], zero fill
  output logic [63:0]                   out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [ecc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecc_pkg::CNT_W-1:0]     cfg_wdata
);
  import ecc_pkg::*;

  cfg_t        cfg_r;
  logic        in_valid_r;
  item_t       item_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        advance;
  logic        in_accept;
  status_t     status;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_time    <= OPEN_TIME_RST;
      cfg_r.dwell_time   <= DWELL_TIME_RST;
      cfg_r.close_time   <= CLOSE_TIME_RST;
      cfg_r.car_capacity <= CAPACITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OPEN_TIME:  cfg_r.open_time    <= cfg_wdata;
        CFG_DWELL_TIME: cfg_r.dwell_time   <= cfg_wdata;
        CFG_CLOSE_TIME: cfg_r.close_time   <= cfg_wdata;
        CFG_CAPACITY:   cfg_r.car_capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.func        <= in_tuser;
      item_r.call_floor  <= in_tdata[3:0];
      item_r.call_dir    <= in_tdata[4];
      item_r.dest_floor  <= in_tdata[8:5];
      item_r.board_count <= in_tdata[16:9];
    end
  end

  ecc_core #(
    .NUM_FLOORS (NUM_FLOORS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (advance),
    .item_i   (item_r),
    .cfg_i    (cfg_r),
    .status_o (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {3'b000, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_SAME(a_door_open_phase, out_valid_r && out_data_r[6], out_data_r[8:7] == PH_OPEN || out_data_r[8:7] == PH_DWELL, "door open outside opening or dwell")
  `ASSERT_NEXT(a_item_kept, in_valid_r && !advance, in_valid_r, "held event item was dropped")
  `ASSERT_NEXT(a_result_shown, advance, out_valid_r, "processed event gave no status item")

endmodule
